// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms with asynchronous reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants of the huffman code bit packer
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;
	localparam int OP_W       = 2;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 4;
	localparam int PEND_W     = 7;
	localparam int PCNT_W     = 3;

	localparam int SYM_LSB  = 0;
	localparam int LEN_LSB  = 8;
	localparam int BITS_LSB = 14;
	localparam int SYM_W    = 8;
	localparam int LEN_W    = 6;
	localparam int BITS_W   = 32;

	localparam logic [CNT_W-1:0] FULL_BYTE = 4'd8;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_PACK,
		ST_SINGLE
	} state_t;

endpackage

// ----- hdl/hcbp_ram.sv -----
// ----------------------------------------------------------------------------
// hcbp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/huffman_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// code table and msb-first byte packer for prefix codes
// ----------------------------------------------------------------------------
// A load item writes one table entry. A flush item returns the pending bits
// right-aligned with their count. An encode item reads the table (registered
// read), then the packer moves up to one byte of code bits per cycle while
// the output register is free; an unmapped symbol gives a single result with
// no bits. The packer waits while the output register is held by the sink.
// The table is cleared at reset through per-entry valid flags, with no sweep.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
	parameter int MAX_CODE_BITS = 32,
	parameter int SYMBOL_COUNT  = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// symbol, code_length, code_bits
	input  logic [hcbp_pkg::IN_DATA_W-1:0]   s_tdata,
	// opcode
	input  logic [hcbp_pkg::OP_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_byte, valid_bits
	output logic [hcbp_pkg::OUT_DATA_W-1:0]  m_tdata,
	// unmapped
	output logic                             m_tuser,
	output logic                             m_tlast
);

	localparam int LW = $clog2(MAX_CODE_BITS + 1);
	localparam int AW = $clog2(SYMBOL_COUNT);
	localparam int EW = LW + MAX_CODE_BITS;
	localparam int CW = (MAX_CODE_BITS > hcbp_pkg::BITS_W) ? MAX_CODE_BITS : hcbp_pkg::BITS_W;

	typedef logic [AW-1:0] idx_tab_t [256];

	function automatic idx_tab_t build_idx_tab();
		idx_tab_t t;
		for (int v = 0; v < 256; v++) begin
			t[v] = AW'(v % SYMBOL_COUNT);
		end
		return t;
	endfunction

	localparam idx_tab_t IDX_TAB = build_idx_tab();

	hcbp_pkg::state_t state_q, state_nxt;
	hcbp_pkg::op_t    op;

	logic [hcbp_pkg::SYM_W-1:0]  sym_in;
	logic [hcbp_pkg::LEN_W-1:0]  len_in;
	logic [hcbp_pkg::BITS_W-1:0] bits_in;
	logic                        accept;
	logic [AW-1:0]               idx;

	logic [LW-1:0]            len_sat;
	logic [CW-1:0]            code_ext;
	logic [MAX_CODE_BITS-1:0] code_masked;
	logic [MAX_CODE_BITS-1:0] code_left;
	logic                     tab_we;
	logic [EW-1:0]            rd_data;
	logic [SYMBOL_COUNT-1:0]  entry_vld_q;
	logic                     vld_rd_q;
	logic [LW-1:0]            rd_len;

	logic [MAX_CODE_BITS-1:0]    code_q;
	logic [LW-1:0]               rem_q;
	logic [hcbp_pkg::PEND_W-1:0] pend_q;
	logic [hcbp_pkg::PCNT_W-1:0] pcnt_q;
	logic                        unm_q;

	logic [hcbp_pkg::CNT_W-1:0]  space;
	logic                        full;
	logic [hcbp_pkg::CNT_W-1:0]  n;
	logic [hcbp_pkg::BYTE_W-1:0] top8;
	logic [15:0]                 acc;
	logic [LW-1:0]               rem_left;
	logic                        out_free;
	logic                        emit_byte;
	logic                        emit_single;

	logic                        m_tvalid_q;
	logic [hcbp_pkg::BYTE_W-1:0] obyte_q;
	logic [hcbp_pkg::CNT_W-1:0]  ovb_q;
	logic                        ounm_q;
	logic                        olast_q;

	// input unpacking
	assign op      = hcbp_pkg::op_t'(s_tuser);
	assign sym_in  = s_tdata[hcbp_pkg::SYM_LSB +: hcbp_pkg::SYM_W];
	assign len_in  = s_tdata[hcbp_pkg::LEN_LSB +: hcbp_pkg::LEN_W];
	assign bits_in = s_tdata[hcbp_pkg::BITS_LSB +: hcbp_pkg::BITS_W];
	assign idx     = IDX_TAB[sym_in];

	assign s_tready = (state_q == hcbp_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// table entry formatting on load
	always_comb begin
		len_sat  = (int'(len_in) > MAX_CODE_BITS) ? LW'(MAX_CODE_BITS) : LW'(len_in);
		code_ext = CW'(bits_in);
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			code_masked[i] = code_ext[i] && (i < int'(len_sat));
		end
		// stored left-aligned, root bit at the top
		code_left = code_masked << (MAX_CODE_BITS - int'(len_sat));
	end

	assign tab_we = accept && (op == hcbp_pkg::OP_LOAD);

	hcbp_ram #(
		.WIDTH (EW),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (idx),
		.wdata ({len_sat, code_left}),
		.raddr (idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
		end else if (tab_we) begin
			entry_vld_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_rd_q <= entry_vld_q[idx];
	end

	assign rd_len = vld_rd_q ? rd_data[EW-1:MAX_CODE_BITS] : '0;

	// packer datapath
	always_comb begin
		space     = hcbp_pkg::FULL_BYTE - hcbp_pkg::CNT_W'(pcnt_q);
		full      = (rem_q >= LW'(space));
		n         = full ? space : rem_q[hcbp_pkg::CNT_W-1:0];
		top8      = code_q[MAX_CODE_BITS-1 -: hcbp_pkg::BYTE_W];
		acc       = (16'(pend_q) << n) | (16'(top8) >> (hcbp_pkg::FULL_BYTE - n));
		rem_left  = rem_q - LW'(n);
		out_free  = !m_tvalid_q || m_tready;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			hcbp_pkg::ST_IDLE: begin
				if (accept && (op == hcbp_pkg::OP_ENCODE)) begin
					state_nxt = hcbp_pkg::ST_LOOKUP;
				end else if (accept && (op == hcbp_pkg::OP_FLUSH)) begin
					state_nxt = hcbp_pkg::ST_SINGLE;
				end
			end
			hcbp_pkg::ST_LOOKUP: begin
				state_nxt = (rd_len == '0) ? hcbp_pkg::ST_SINGLE : hcbp_pkg::ST_PACK;
			end
			hcbp_pkg::ST_PACK: begin
				if (!full) begin
					state_nxt = hcbp_pkg::ST_IDLE;
				end else if (out_free && (rem_left == '0)) begin
					state_nxt = hcbp_pkg::ST_IDLE;
				end
			end
			hcbp_pkg::ST_SINGLE: begin
				if (out_free) begin
					state_nxt = hcbp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = hcbp_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		emit_byte   = 1'b0;
		emit_single = 1'b0;
		unique case (state_q)
			hcbp_pkg::ST_PACK:   emit_byte   = full && out_free;
			hcbp_pkg::ST_SINGLE: emit_single = out_free;
			default: begin
				emit_byte   = 1'b0;
				emit_single = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcbp_pkg::ST_IDLE;
			rem_q   <= '0;
			pend_q  <= '0;
			pcnt_q  <= '0;
			unm_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				unm_q <= 1'b0;
			end
			if (state_q == hcbp_pkg::ST_LOOKUP) begin
				rem_q <= rd_len;
				unm_q <= (rd_len == '0);
			end
			if ((state_q == hcbp_pkg::ST_PACK) && !full) begin
				pend_q <= acc[hcbp_pkg::PEND_W-1:0];
				pcnt_q <= pcnt_q + n[hcbp_pkg::PCNT_W-1:0];
				rem_q  <= '0;
			end
			if (emit_byte) begin
				pend_q <= '0;
				pcnt_q <= '0;
				rem_q  <= rem_left;
			end
			if (emit_single && !unm_q) begin
				pend_q <= '0;
				pcnt_q <= '0;
			end
		end
	end

	// code shift register
	always_ff @(posedge clk) begin
		if (state_q == hcbp_pkg::ST_LOOKUP) begin
			code_q <= rd_data[MAX_CODE_BITS-1:0];
		end else if (emit_byte) begin
			code_q <= code_q << n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_byte || emit_single) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_byte) begin
			obyte_q <= acc[hcbp_pkg::BYTE_W-1:0];
			ovb_q   <= hcbp_pkg::FULL_BYTE;
			ounm_q  <= 1'b0;
			olast_q <= (rem_left < LW'(hcbp_pkg::FULL_BYTE));
		end else if (emit_single) begin
			obyte_q <= unm_q ? '0 : hcbp_pkg::BYTE_W'(pend_q);
			ovb_q   <= unm_q ? '0 : hcbp_pkg::CNT_W'(pcnt_q);
			ounm_q  <= unm_q;
			olast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(hcbp_pkg::OUT_DATA_W - hcbp_pkg::BYTE_W - hcbp_pkg::CNT_W){1'b0}},
		ovb_q, obyte_q};
	assign m_tuser  = ounm_q;
	assign m_tlast  = olast_q;

endmodule

// ----- hdl/hcbp_checker.sv -----
// ----------------------------------------------------------------------------
// hcbp_checker
// port-level checks on the result stream of the bit packer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [hcbp_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic [hcbp_pkg::OP_W-1:0]        s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [hcbp_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);

	logic [hcbp_pkg::CNT_W-1:0] vb;
	logic                       in_load;

	assign vb      = m_tdata[hcbp_pkg::BYTE_W +: hcbp_pkg::CNT_W];
	assign in_load = s_tvalid && s_tready && (s_tuser == hcbp_pkg::OP_LOAD)
		&& (s_tdata[hcbp_pkg::LEN_LSB +: hcbp_pkg::LEN_W] != '0);

	// result held until taken
	`ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// unmapped result carries no bits and closes the item
	`ASSERT_IMP(a_unmapped, clk, arst_n, m_tvalid && m_tuser, (m_tdata == '0) && m_tlast)

	// only the final result of an item may be a partial byte
	`ASSERT_IMP(a_partial, clk, arst_n, m_tvalid && !m_tlast, vb == hcbp_pkg::FULL_BYTE)

	// a load item produces no result in the next cycle
	`ASSERT_NXT(a_load, clk, arst_n, in_load && !m_tvalid, !m_tvalid)

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (.*);
